// ===== hdl/mstep_pkg.sv =====
// Shared constants and types for the minimum-steps-to-one block.
package mstep_pkg;

    localparam int TABLE_SIZE = 1024;
    localparam int TABLE_AW   = $clog2(TABLE_SIZE);
    localparam int QUERY_W    = 10;
    localparam int STEP_W     = 6;

    typedef logic [TABLE_AW-1:0] t_addr;
    typedef logic [QUERY_W-1:0]  t_query;
    typedef logic [STEP_W-1:0]   t_step;

    localparam t_step STEP_MAX = '1;

endpackage

// ===== hdl/mstep_ifs.sv =====
// Valid/ready channel interfaces for the query and result items.
interface mstep_in_if;
    logic                  valid;
    logic                  ready;
    mstep_pkg::t_query     query_value;

    modport source (output valid, output query_value, input ready);
    modport sink   (input valid, input query_value, output ready);
endinterface

interface mstep_out_if;
    logic                  valid;
    logic                  ready;
    mstep_pkg::t_step      step_count;

    modport source (output valid, output step_count, input ready);
    modport sink   (input valid, input step_count, output ready);
endinterface

// ===== hdl/min_steps_to_one_core.sv =====
// Top level: fills the step table bottom-up for each query and returns the entry for n.
//
//   Channel    Direction  Handshake       Payload
//   i_query    in         valid/ready     query_value [9:0]
//   o_result   out        valid/ready     step_count  [5:0]
//
// A query n of 0 or 1 goes straight to the output register; otherwise the table walk
// reads and then writes each entry from 2 to n in turn, and the last one written is the result.
// The walk is paced by the two-read-port table memory, read in one cycle and written in the next.
// Reset is synchronous and active low; the table itself is not cleared.
// The block takes no new item until the result item has been taken downstream.
module min_steps_to_one_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    mstep_in_if.sink     i_query,
    mstep_out_if.source  o_result
);
    import mstep_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_UPDATE,
        S_OUT
    } t_state;

    t_state      r_state;
    t_addr       r_n;
    t_addr       r_i;
    t_addr       r_third;
    logic [1:0]  r_mod3;
    t_step       r_prev;
    t_step       r_out;

    t_step       r_mem [TABLE_SIZE];
    t_step       r_rd_half;
    t_step       r_rd_third;

    t_addr       n_sat;
    t_addr       n_half;
    t_step       n_opa;
    t_step       n_opb;
    t_step       n_best;
    t_step       n_val;

    assign n_sat = (32'(i_query.query_value) > 32'(TABLE_SIZE - 1))
                   ? t_addr'(TABLE_SIZE - 1) : t_addr'(i_query.query_value);
    assign n_half = r_i >> 1;

    always_comb begin
        n_opa = STEP_MAX;
        n_opb = STEP_MAX;
        if (!r_i[0]) begin
            n_opa = (r_i == t_addr'(2)) ? '0 : r_rd_half;
        end
        if (r_mod3 == 2'd0) begin
            n_opb = (r_third == t_addr'(1)) ? '0 : r_rd_third;
        end
        n_best = r_prev;
        if (n_opa < n_best) begin
            n_best = n_opa;
        end
        if (n_opb < n_best) begin
            n_best = n_opb;
        end
        n_val = (n_best == STEP_MAX) ? STEP_MAX : n_best + t_step'(1);
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_READ) begin
            r_rd_half  <= r_mem[n_half];
            r_rd_third <= r_mem[r_third];
        end
        if (r_state == S_UPDATE) begin
            r_mem[r_i] <= n_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_query.valid) begin
                        r_n     <= n_sat;
                        r_i     <= t_addr'(2);
                        r_third <= '0;
                        r_mod3  <= 2'd2;
                        r_prev  <= '0;
                        r_out   <= '0;
                        r_state <= (n_sat < t_addr'(2)) ? S_OUT : S_READ;
                    end
                end
                S_READ: begin
                    r_state <= S_UPDATE;
                end
                S_UPDATE: begin
                    r_prev <= n_val;
                    if (r_i == r_n) begin
                        r_out   <= n_val;
                        r_state <= S_OUT;
                    end else begin
                        r_i <= r_i + t_addr'(1);
                        if (r_mod3 == 2'd2) begin
                            r_mod3  <= 2'd0;
                            r_third <= r_third + t_addr'(1);
                        end else begin
                            r_mod3 <= r_mod3 + 2'd1;
                        end
                        r_state <= S_READ;
                    end
                end
                S_OUT: begin
                    if (o_result.ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_query.ready       = (r_state == S_IDLE);
    assign o_result.valid      = (r_state == S_OUT);
    assign o_result.step_count = r_out;

endmodule

// ===== hdl/mstep_chk.sv =====
// Port-level assertion checker for the minimum-steps-to-one block, with its bind.
module mstep_chk (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_ready,
    input  mstep_pkg::t_query i_in_query,
    input  logic              i_out_valid,
    input  logic              i_out_ready,
    input  mstep_pkg::t_step  i_out_count
);
    import mstep_pkg::*;

    // A result item waiting downstream holds its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_count)))
        else $error("result item changed while stalled");

    // The block never offers a result while it takes a query.
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in_ready && i_out_valid))
        else $error("ready for a query while a result is pending");

    // Once a query is taken, no further query is taken in the next cycle.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("query taken while busy");

    // A query of zero or one gives its result at once.
    a_trivial: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready && (i_in_query == t_query'(0) || i_in_query == t_query'(1)))
        |=> (i_out_valid && i_out_count == '0))
        else $error("trivial query did not give zero at once");

    // After the result is taken, the block is ready for the next query.
    a_return: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_ready) |=> i_in_ready)
        else $error("block not ready after result taken");

endmodule

bind min_steps_to_one_core mstep_chk u_mstep_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_query.valid),
    .i_in_ready  (i_query.ready),
    .i_in_query  (i_query.query_value),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_out_count (o_result.step_count)
);

// ===== tb/sv/min_steps_to_one_core_test.sv =====
// Self-checking testbench for min_steps_to_one_core: queries, predicted step counts and scoreboard.
module min_steps_to_one_core_test;
    import mstep_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int HOLD_OFF_LEN   = 500;

    logic i_clk = 1'b0;
    logic i_rst_n;

    mstep_in_if  query_ch ();
    mstep_out_if result_ch ();

    min_steps_to_one_core DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_query  (query_ch),
        .o_result (result_ch)
    );

    always #5 i_clk = ~i_clk;

    t_step step_memo [TABLE_SIZE];
    t_step step_queue [$];
    int    error_count  = 0;
    bit    idle_enable  = 1'b1;
    int    hold_off_req = 0;
    int    stall_left   = 0;
    int    quiet_cycles = 0;

    function automatic t_step compute_min_steps(input t_query q);
        int n;
        int k;
        int best;
        n = int'(q);
        if (n > TABLE_SIZE - 1) begin
            n = TABLE_SIZE - 1;
        end
        step_memo[0] = '0;
        step_memo[1] = '0;
        for (k = 2; k <= n; k++) begin
            best = int'(step_memo[k-1]);
            if (k % 2 == 0 && int'(step_memo[k/2]) < best) begin
                best = int'(step_memo[k/2]);
            end
            if (k % 3 == 0 && int'(step_memo[k/3]) < best) begin
                best = int'(step_memo[k/3]);
            end
            best = best + 1;
            if (best > int'(STEP_MAX)) begin
                best = int'(STEP_MAX);
            end
            step_memo[k] = t_step'(best);
        end
        return step_memo[n];
    endfunction

    task automatic report_mismatch(input string what, input int expected_val, input int got_val);
        $display("mismatch at %0t: %s (expected %0d, got %0d)", $time, what, expected_val,
                 got_val);
        error_count++;
    endtask

    task automatic send_query(input t_query q);
        int gap;
        if (idle_enable && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 4);
            query_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        query_ch.valid       <= 1'b1;
        query_ch.query_value <= q;
        @(posedge i_clk);
        while (!query_ch.ready) @(posedge i_clk);
        step_queue.push_back(compute_min_steps(q));
        @(negedge i_clk);
    endtask

    task automatic idle_input();
        query_ch.valid <= 1'b0;
    endtask

    task automatic wait_for_results();
        idle_input();
        while (step_queue.size() != 0) @(negedge i_clk);
    endtask

    task automatic test_directed();
        t_query corner [25];
        corner = '{10'd0, 10'd1, 10'd2, 10'd3, 10'd4, 10'd5, 10'd6, 10'd7, 10'd8, 10'd9,
                   10'd10, 10'd27, 10'd64, 10'd81, 10'd127, 10'd128, 10'd341, 10'd512,
                   10'd682, 10'd729, 10'h155, 10'h2AA, 10'd1000, 10'd1022, 10'd1023};
        foreach (corner[k]) begin
            send_query(corner[k]);
        end
    endtask

    task automatic test_back_pressure();
        idle_input();
        @(posedge i_clk);
        hold_off_req = HOLD_OFF_LEN;
        @(negedge i_clk);
        repeat (6) begin
            send_query(t_query'($urandom_range(0, 40)));
        end
    endtask

    task automatic test_drain_pause();
        wait_for_results();
        repeat (4) begin
            send_query(t_query'($urandom_range(0, 100)));
        end
        wait_for_results();
    endtask

    task automatic test_random(input int count);
        int pick;
        t_query q;
        repeat (count) begin
            pick = $urandom_range(0, 9);
            if (pick < 7) begin
                q = t_query'($urandom_range(0, 40));
            end else if (pick < 9) begin
                q = t_query'($urandom_range(0, 255));
            end else begin
                q = t_query'($urandom);
            end
            send_query(q);
        end
    endtask

    task automatic test_no_idle(input int count);
        idle_input();
        @(posedge i_clk);
        idle_enable = 1'b0;
        @(negedge i_clk);
        test_random(count);
    endtask

    always @(negedge i_clk) begin
        if (stall_left == 0 && hold_off_req != 0) begin
            stall_left   = hold_off_req;
            hold_off_req = 0;
        end
        if (stall_left == 0 && idle_enable && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 4);
        end
        if (stall_left > 0) begin
            result_ch.ready <= 1'b0;
            stall_left--;
        end else begin
            result_ch.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : check_results
        t_step want;
        if (i_rst_n && result_ch.valid && result_ch.ready) begin
            if (step_queue.size() == 0) begin
                report_mismatch("result item with no query pending", -1,
                                int'(result_ch.step_count));
            end else begin
                want = step_queue.pop_front();
                if (result_ch.step_count !== want) begin
                    report_mismatch("step_count", int'(want), int'(result_ch.step_count));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((query_ch.valid && query_ch.ready) || (result_ch.valid && result_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        i_rst_n              = 1'b0;
        query_ch.valid       = 1'b0;
        query_ch.query_value = '0;
        result_ch.ready      = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed();
        test_back_pressure();
        test_drain_pause();
        test_random(230);
        test_no_idle(25);

        wait_for_results();
        repeat (50) @(posedge i_clk);
        if (error_count == 0 && step_queue.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
